[design/ddo_pkg.sv]
// shared constants and helper functions for the differential drive odometry block
package ddo_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_WHEEL_RADIUS = 2'd0;
  localparam logic [1:0] CFG_TURN_GAIN    = 2'd1;

  localparam logic [16:0] WHEEL_RADIUS_RESET = 17'd13107;
  localparam logic [20:0] TURN_GAIN_RESET    = 21'd65536;

  // 2*pi in q16.16, and a multiple of it that lifts any 32-bit heading above zero
  localparam logic [33:0]        RED_MOD   = 34'd411775;
  localparam logic signed [33:0] RED_BIAS  = 34'sd2147818400;
  localparam int unsigned        RED_TOP   = 13;

  // quadrant folding bounds in q16.16
  localparam logic signed [19:0] Q_HALF_PI = 20'sd102944;
  localparam logic signed [19:0] Q_PI      = 20'sd205887;
  localparam logic signed [19:0] Q_PI_UP   = 20'sd205888;
  localparam logic signed [19:0] Q_FOLD_HI = 20'sd308831;
  localparam logic signed [19:0] Q_TWO_PI  = 20'sd411775;

  // limiting cordic gain in q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // arctangent of 2^-i in q2.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:    a = 34'sd843314857;
      5'd1:    a = 34'sd497837828;
      5'd2:    a = 34'sd263043837;
      5'd3:    a = 34'sd133525159;
      5'd4:    a = 34'sd67021687;
      5'd5:    a = 34'sd33543516;
      5'd6:    a = 34'sd16775851;
      5'd7:    a = 34'sd8388437;
      5'd8:    a = 34'sd4194283;
      5'd9:    a = 34'sd2097149;
      5'd10:   a = 34'sd1048576;
      5'd11:   a = 34'sd524288;
      5'd12:   a = 34'sd262144;
      5'd13:   a = 34'sd131072;
      5'd14:   a = 34'sd65536;
      5'd15:   a = 34'sd32768;
      5'd16:   a = 34'sd16384;
      5'd17:   a = 34'sd8192;
      5'd18:   a = 34'sd4096;
      5'd19:   a = 34'sd2048;
      5'd20:   a = 34'sd1024;
      5'd21:   a = 34'sd512;
      5'd22:   a = 34'sd256;
      5'd23:   a = 34'sd128;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

[design/diff_drive_odometry.sv]
// differential drive wheel odometry with a shared multiplier and an iterative cordic
//
// usage:
//   sample channel: sample_valid / sample_stall carry left_wheel_angle and
//   right_wheel_angle (absolute wheel angles, signed q16.16). the block holds
//   sample_stall high while it works on a sample.
//   pose channel: pose_valid / pose_stall carry pose_x, pose_y, heading,
//   heading_step and travelled, one result per sample.
//   configuration: cfg_write with cfg_index 0 writes wheel_radius, index 1
//   writes turn_gain; other indexes are ignored. write only while idle.
// operation:
//   one 33x33 multiplier is reused for both arcs, the heading step, the heading
//   and the x/y projection; the heading is reduced modulo 2*pi by 14 shift and
//   subtract steps, then a cordic runs CORDIC_STEPS iterations.
//   the next sample is accepted while a finished result still waits; if the
//   receiver stalls, the following result waits in its last step until the
//   output register frees up.
// reset: accumulators, previous arcs and totals clear, registers return to
//   wheel_radius 0.2 and turn_gain 1.0, no result is pending.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [31:0] left_wheel_angle,
  input  logic signed [31:0] right_wheel_angle,
  output logic               pose_valid,
  input  logic               pose_stall,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [31:0] heading,
  output logic signed [31:0] heading_step,
  output logic signed [31:0] travelled,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [20:0]        cfg_data
);

  localparam int ITER_W = $clog2(CORDIC_STEPS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ML   = 4'd1;
  localparam logic [3:0] S_DL   = 4'd2;
  localparam logic [3:0] S_DR   = 4'd3;
  localparam logic [3:0] S_TOT  = 4'd4;
  localparam logic [3:0] S_HS   = 4'd5;
  localparam logic [3:0] S_HD   = 4'd6;
  localparam logic [3:0] S_RED0 = 4'd7;
  localparam logic [3:0] S_RED  = 4'd8;
  localparam logic [3:0] S_FOLD = 4'd9;
  localparam logic [3:0] S_CORD = 4'd10;
  localparam logic [3:0] S_SIGN = 4'd11;
  localparam logic [3:0] S_PX   = 4'd12;
  localparam logic [3:0] S_PY   = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0]  state;
  logic [16:0] wheel_radius;
  logic [20:0] turn_gain;

  logic signed [31:0] left_angle, right_angle;
  logic signed [31:0] prev_left_arc, prev_right_arc;
  logic signed [31:0] left_total, right_total, centre_total;
  logic signed [31:0] x_accum, y_accum;
  logic signed [31:0] left_step, right_step, centre_step;
  logic signed [31:0] head, head_step;

  logic signed [65:0] prod;
  logic signed [65:0] mul_out;
  logic signed [32:0] mul_a, mul_b;

  logic [32:0] red_val;
  logic [3:0]  red_k;

  logic signed [33:0] cx, cy, cz;
  logic [ITER_W-1:0]  iter;
  logic               flip;

  logic signed [31:0] prod_q16, arc_prev, step_new, acc_old, acc_new;
  logic signed [32:0] pair_sum;
  logic [33:0]        red_sub;
  logic signed [19:0] fold_v, fold_r;
  logic               fold_neg;
  logic signed [33:0] cx_sh, cy_sh, ang;
  logic               out_free;

  assign sample_stall = (state != S_IDLE);
  assign out_free     = !pose_valid || !pose_stall;

  // shared multiplier operand selection
  always_comb begin
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    case (state)
      S_ML: begin
        mul_a = 33'(left_angle);
        mul_b = $signed({16'd0, wheel_radius});
      end
      S_DL: begin
        mul_a = 33'(right_angle);
        mul_b = $signed({16'd0, wheel_radius});
      end
      S_TOT: begin
        mul_a = 33'(right_step) - 33'(left_step);
        mul_b = $signed({12'd0, turn_gain});
      end
      S_HS: begin
        mul_a = 33'(right_total) - 33'(left_total);
        mul_b = $signed({12'd0, turn_gain});
      end
      S_PX: begin
        mul_a = 33'(centre_step);
        mul_b = $signed(cx[32:0]);
      end
      S_PY: begin
        mul_a = 33'(centre_step);
        mul_b = $signed(cy[32:0]);
      end
      default: begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  assign mul_out = 66'(mul_a) * 66'(mul_b);

  always_comb begin
    prod_q16 = ddo_pkg::sat32(68'(prod >>> 16));
    arc_prev = (state == S_DL) ? prev_left_arc : prev_right_arc;
    step_new = ddo_pkg::sat32(68'(33'(prod_q16) - 33'(arc_prev)));
    acc_old  = (state == S_PY) ? x_accum : y_accum;
    acc_new  = ddo_pkg::sat32(68'(prod >>> 30) + 68'(acc_old));
    pair_sum = 33'(left_step) + 33'(right_step);
    red_sub  = ddo_pkg::RED_MOD << red_k;
  end

  // fold the reduced angle into [-pi/2, pi/2]
  always_comb begin
    fold_v = $signed({1'b0, red_val[18:0]});
    if (fold_v <= ddo_pkg::Q_HALF_PI) begin
      fold_r   = fold_v;
      fold_neg = 1'b0;
    end else if (fold_v <= ddo_pkg::Q_PI) begin
      fold_r   = fold_v - ddo_pkg::Q_PI;
      fold_neg = 1'b1;
    end else if (fold_v < ddo_pkg::Q_FOLD_HI) begin
      fold_r   = fold_v - ddo_pkg::Q_PI_UP;
      fold_neg = 1'b1;
    end else begin
      fold_r   = fold_v - ddo_pkg::Q_TWO_PI;
      fold_neg = 1'b0;
    end
  end

  always_comb begin
    cx_sh = cx >>> iter;
    cy_sh = cy >>> iter;
    ang   = ddo_pkg::atan_q30(5'(iter));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      wheel_radius   <= ddo_pkg::WHEEL_RADIUS_RESET;
      turn_gain      <= ddo_pkg::TURN_GAIN_RESET;
      prev_left_arc  <= 32'sd0;
      prev_right_arc <= 32'sd0;
      left_total     <= 32'sd0;
      right_total    <= 32'sd0;
      centre_total   <= 32'sd0;
      x_accum        <= 32'sd0;
      y_accum        <= 32'sd0;
      pose_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ddo_pkg::CFG_WHEEL_RADIUS: wheel_radius <= cfg_data[16:0];
          ddo_pkg::CFG_TURN_GAIN:    turn_gain    <= cfg_data;
          default: ;
        endcase
      end

      if (state == S_FIN && out_free) begin
        pose_valid <= 1'b1;
      end else if (!pose_stall) begin
        pose_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            left_angle  <= left_wheel_angle;
            right_angle <= right_wheel_angle;
            state       <= S_ML;
          end
        end
        S_ML: begin
          prod  <= mul_out;
          state <= S_DL;
        end
        S_DL: begin
          left_step     <= step_new;
          prev_left_arc <= prod_q16;
          prod          <= mul_out;
          state         <= S_DR;
        end
        S_DR: begin
          right_step     <= step_new;
          prev_right_arc <= prod_q16;
          state          <= S_TOT;
        end
        S_TOT: begin
          left_total  <= ddo_pkg::sat32(68'(left_total) + 68'(left_step));
          right_total <= ddo_pkg::sat32(68'(right_total) + 68'(right_step));
          centre_step <= pair_sum[32:1];
          prod        <= mul_out;
          state       <= S_HS;
        end
        S_HS: begin
          head_step    <= prod_q16;
          centre_total <= ddo_pkg::sat32(68'(centre_total) + 68'(centre_step));
          prod         <= mul_out;
          state        <= S_HD;
        end
        S_HD: begin
          head  <= prod_q16;
          state <= S_RED0;
        end
        S_RED0: begin
          red_val <= 33'(34'(head) + ddo_pkg::RED_BIAS);
          red_k   <= 4'(ddo_pkg::RED_TOP);
          state   <= S_RED;
        end
        S_RED: begin
          // restoring reduction by 2*pi times a falling power of two
          if ({1'b0, red_val} >= red_sub) begin
            red_val <= red_val - red_sub[32:0];
          end
          red_k <= red_k - 4'd1;
          if (red_k == 4'd0) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          cz    <= 34'(fold_r) <<< 14;
          cx    <= ddo_pkg::CORDIC_GAIN;
          cy    <= 34'sd0;
          flip  <= fold_neg;
          iter  <= '0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (!cz[33]) begin
            cx <= cx - cy_sh;
            cy <= cy + cx_sh;
            cz <= cz - ang;
          end else begin
            cx <= cx + cy_sh;
            cy <= cy - cx_sh;
            cz <= cz + ang;
          end
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (flip) begin
            cx <= -cx;
            cy <= -cy;
          end
          state <= S_PX;
        end
        S_PX: begin
          prod  <= mul_out;
          state <= S_PY;
        end
        S_PY: begin
          x_accum <= acc_new;
          prod    <= mul_out;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            y_accum      <= acc_new;
            pose_x       <= x_accum;
            pose_y       <= acc_new;
            heading      <= head;
            heading_step <= head_step;
            travelled    <= centre_total;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[design/ddo_check.sv]
// port level checks for the odometry block and their bind
module ddo_check (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic               pose_valid,
  input logic               pose_stall,
  input logic signed [31:0] pose_x,
  input logic signed [31:0] pose_y
);

  // a transfer of a sample makes the block busy
  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("block not busy after a sample transfer");

  // a fresh result only follows a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(pose_valid) |-> $past(sample_stall))
    else $error("result appeared without work in progress");

  // no result can come right after a sample transfer
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> !$rose(pose_valid))
    else $error("result came one cycle after a sample transfer");

  // reset leaves the block idle with nothing pending
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !pose_valid && !sample_stall)
    else $error("block not idle after reset");

  // a stalled result holds
  a_stalled_holds: assert property (@(posedge clk) disable iff (rst)
    pose_valid && pose_stall |=> pose_valid && $stable(pose_x) && $stable(pose_y))
    else $error("stalled result changed");

endmodule

bind diff_drive_odometry ddo_check u_ddo_check (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .pose_valid   (pose_valid),
  .pose_stall   (pose_stall),
  .pose_x       (pose_x),
  .pose_y       (pose_y)
);
